/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used by the one checker file, rasbm_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define RASBM_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rasbm check failed");

// Check cons in the cycle after ante.
`define RASBM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rasbm check failed");

`endif

/* rtl/rasbm_pkg.sv */
// ----------------------------------------------------------------------------
// rasbm_pkg
// Sizes, codes and helper tables of the recent-average SSD best-match block.
// ----------------------------------------------------------------------------
package rasbm_pkg;

    localparam int WINDOW_IMAGES    = 4;
    localparam int PIXELS_PER_IMAGE = 4096;
    localparam int MAX_CANDIDATES   = 1024;

    localparam int COLOR_W = 8;
    localparam int NUM_W   = 10;
    localparam int DIST_W  = 30;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam int LANE_W = 3 * COLOR_W;
    localparam int ROW_W  = LANE_W * WINDOW_IMAGES;
    localparam int POS_W  = (PIXELS_PER_IMAGE > 1) ? $clog2(PIXELS_PER_IMAGE) : 1;
    localparam int SLOT_W = (WINDOW_IMAGES > 1) ? $clog2(WINDOW_IMAGES) : 1;
    localparam int FILL_W = $clog2(WINDOW_IMAGES + 1);
    localparam int CNT_W  = $clog2(MAX_CANDIDATES);
    localparam int SUM_W  = COLOR_W + $clog2(WINDOW_IMAGES);

    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_IDX_W = 4;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int SQ_W        = 2 * COLOR_W;
    localparam int PX_W        = SQ_W + 2;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_CAND = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SCALE,
        ST_SQUARE,
        ST_ACCUM
    } state_t;

    // ceil(2^16 / n); zero for an empty window gives a zero average
    function automatic logic [RECIP_W-1:0] recip_lookup(input logic [RECIP_IDX_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/rasbm_in_if.sv */
// ----------------------------------------------------------------------------
// rasbm_in_if
// Pixel channel: valid/ready handshake with opcode, colour and framing bits.
// ----------------------------------------------------------------------------
interface rasbm_in_if
    import rasbm_pkg::*;
();

    logic               valid;
    logic               ready;
    logic               opcode;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last_pixel;
    logic               last_candidate;

    modport source
    (
        output valid,
        output opcode,
        output red,
        output green,
        output blue,
        output last_pixel,
        output last_candidate,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  opcode,
        input  red,
        input  green,
        input  blue,
        input  last_pixel,
        input  last_candidate,
        output ready
    );

endinterface

/* rtl/rasbm_out_if.sv */
// ----------------------------------------------------------------------------
// rasbm_out_if
// Result channel: valid/ready handshake with candidate distance and best match.
// ----------------------------------------------------------------------------
interface rasbm_out_if
    import rasbm_pkg::*;
();

    logic              valid;
    logic              ready;
    logic [NUM_W-1:0]  candidate_number;
    logic [DIST_W-1:0] distance;
    logic [NUM_W-1:0]  best_number;
    logic [DIST_W-1:0] best_distance;
    logic              search_done;

    modport source
    (
        output valid,
        output candidate_number,
        output distance,
        output best_number,
        output best_distance,
        output search_done,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  candidate_number,
        input  distance,
        input  best_number,
        input  best_distance,
        input  search_done,
        output ready
    );

endinterface

/* rtl/rasbm_ram.sv */
// ----------------------------------------------------------------------------
// rasbm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rasbm_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/recent_average_ssd_best_match.sv */
// ----------------------------------------------------------------------------
// recent_average_ssd_best_match
// Sum-of-squared-differences match of candidates against a window average.
//
// Channels: pixel (sink) takes one pixel word per handshake; opcode 0 writes
// it into the slot of the image being loaded, opcode 1 compares it with the
// per-pixel average of the complete images in the window. result (source)
// gives one word at the last pixel of each candidate: its number, distance,
// and the running best (first strict minimum wins); search_done closes the
// search and resets the candidate count and best.
// Pixels: a pixel is taken only in the idle state, once the last one is
// through; each needs one read of the window row from the single-port-read
// memory, followed, for candidates, by sum, scale, square and accumulate
// steps. A result word is registered as its last pixel leaves accumulate.
// The window row holds all slots of one pixel position, so a load pixel is a
// read-modify-write of that row.
// Reset: counters, fill and best clear at once; window contents are undefined
// until written, no clearing pass is run.
// Stall: the result register holds while result.ready is low; further pixels
// are still taken until another result word is due, then the block waits.
// ----------------------------------------------------------------------------
module recent_average_ssd_best_match
    import rasbm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rasbm_in_if.sink  pixel,
    rasbm_out_if.source result
);

    state_t state_reg;
    state_t state_next;

    logic               op_reg;
    logic [COLOR_W-1:0] red_reg;
    logic [COLOR_W-1:0] green_reg;
    logic [COLOR_W-1:0] blue_reg;
    logic               last_reg;
    logic               last_cand_reg;

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [DIST_W-1:0] dist_reg;
    logic [DIST_W-1:0] dist_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [DIST_W-1:0] best_sum_reg;
    logic [DIST_W-1:0] best_sum_next;
    logic [CNT_W-1:0]  best_idx_reg;
    logic [CNT_W-1:0]  best_idx_next;

    logic [SUM_W-1:0]   sum_r_reg;
    logic [SUM_W-1:0]   sum_g_reg;
    logic [SUM_W-1:0]   sum_b_reg;
    logic [COLOR_W-1:0] avg_r_reg;
    logic [COLOR_W-1:0] avg_g_reg;
    logic [COLOR_W-1:0] avg_b_reg;
    logic [SQ_W-1:0]    sq_r_reg;
    logic [SQ_W-1:0]    sq_g_reg;
    logic [SQ_W-1:0]    sq_b_reg;

    logic              res_valid_reg;
    logic              res_valid_next;
    logic [NUM_W-1:0]  res_cand_reg;
    logic [DIST_W-1:0] res_dist_reg;
    logic [NUM_W-1:0]  res_best_num_reg;
    logic [DIST_W-1:0] res_best_dist_reg;
    logic              res_done_reg;

    logic pixel_ready;
    logic ram_re;
    logic ram_we;
    logic out_busy;
    logic acc_done;
    logic res_load;

    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] ram_wdata;

    logic [SUM_W-1:0]   sum_r;
    logic [SUM_W-1:0]   sum_g;
    logic [SUM_W-1:0]   sum_b;
    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  prod_r;
    logic [PROD_W-1:0]  prod_g;
    logic [PROD_W-1:0]  prod_b;
    logic [COLOR_W-1:0] diff_r;
    logic [COLOR_W-1:0] diff_g;
    logic [COLOR_W-1:0] diff_b;
    logic [PX_W-1:0]    px;
    logic [DIST_W:0]    total;
    logic [DIST_W-1:0]  dist_sat;
    logic               take_best;
    logic [DIST_W-1:0]  new_best_sum;
    logic [CNT_W-1:0]   new_best_idx;
    logic [POS_W-1:0]   pos_adv;

    rasbm_ram
    #(
        .WIDTH (ROW_W),
        .DEPTH (PIXELS_PER_IMAGE)
    )
    u_window_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    assign out_busy = res_valid_reg && !result.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pixel.valid)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (op_reg == OP_LOAD)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:  state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_ACCUM;
            ST_ACCUM:
            begin
                if (!(last_reg && out_busy))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pixel_ready = 1'b0;
        ram_re      = 1'b0;
        ram_we      = 1'b0;
        acc_done    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pixel_ready = 1'b1;
                ram_re      = pixel.valid;
            end
            ST_FETCH:
            begin
                ram_we = (op_reg == OP_LOAD);
            end
            ST_ACCUM:
            begin
                acc_done = !(last_reg && out_busy);
            end
            default:
            begin
                pixel_ready = 1'b0;
            end
        endcase
    end

    assign pixel.ready = pixel_ready;
    assign res_load    = acc_done && last_reg;

    // merge the new pixel into its slot of the row
    always_comb
    begin
        ram_wdata = ram_rdata;
        ram_wdata[slot_reg * LANE_W +: LANE_W] = {red_reg, green_reg, blue_reg};
    end

    // add the complete images of the window
    always_comb
    begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int k = 0; k < WINDOW_IMAGES; k++)
        begin
            if (FILL_W'(k) < fill_reg)
            begin
                sum_r = sum_r + SUM_W'(ram_rdata[k * LANE_W + 2 * COLOR_W +: COLOR_W]);
                sum_g = sum_g + SUM_W'(ram_rdata[k * LANE_W + COLOR_W +: COLOR_W]);
                sum_b = sum_b + SUM_W'(ram_rdata[k * LANE_W +: COLOR_W]);
            end
        end
    end

    assign recip  = recip_lookup(RECIP_IDX_W'(fill_reg));
    assign prod_r = PROD_W'(sum_r_reg) * PROD_W'(recip);
    assign prod_g = PROD_W'(sum_g_reg) * PROD_W'(recip);
    assign prod_b = PROD_W'(sum_b_reg) * PROD_W'(recip);

    assign diff_r = (red_reg > avg_r_reg) ? red_reg - avg_r_reg : avg_r_reg - red_reg;
    assign diff_g = (green_reg > avg_g_reg) ? green_reg - avg_g_reg : avg_g_reg - green_reg;
    assign diff_b = (blue_reg > avg_b_reg) ? blue_reg - avg_b_reg : avg_b_reg - blue_reg;

    assign px       = PX_W'(sq_r_reg) + PX_W'(sq_g_reg) + PX_W'(sq_b_reg);
    assign total    = (DIST_W + 1)'(dist_reg) + (DIST_W + 1)'(px);
    assign dist_sat = total[DIST_W] ? DIST_MAX : total[DIST_W-1:0];

    assign take_best    = (cnt_reg == '0) || (dist_sat < best_sum_reg);
    assign new_best_sum = take_best ? dist_sat : best_sum_reg;
    assign new_best_idx = take_best ? cnt_reg : best_idx_reg;

    assign pos_adv = (pos_reg == POS_W'(PIXELS_PER_IMAGE - 1)) ? '0 : pos_reg + 1'b1;

    always_comb
    begin
        pos_next      = pos_reg;
        slot_next     = slot_reg;
        fill_next     = fill_reg;
        dist_next     = dist_reg;
        cnt_next      = cnt_reg;
        best_sum_next = best_sum_reg;
        best_idx_next = best_idx_reg;

        if (ram_we)
        begin
            if (last_reg)
            begin
                pos_next  = '0;
                slot_next = (slot_reg == SLOT_W'(WINDOW_IMAGES - 1)) ? '0 : slot_reg + 1'b1;
                if (fill_reg < FILL_W'(WINDOW_IMAGES))
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            else
            begin
                pos_next = pos_adv;
            end
        end

        if (acc_done)
        begin
            if (!last_reg)
            begin
                dist_next = dist_sat;
                pos_next  = pos_adv;
            end
            else
            begin
                dist_next = '0;
                pos_next  = '0;
                if (last_cand_reg)
                begin
                    cnt_next      = '0;
                    best_sum_next = DIST_MAX;
                    best_idx_next = '0;
                end
                else
                begin
                    best_sum_next = new_best_sum;
                    best_idx_next = new_best_idx;
                    if (cnt_reg < CNT_W'(MAX_CANDIDATES - 1))
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            slot_reg      <= '0;
            fill_reg      <= '0;
            dist_reg      <= '0;
            cnt_reg       <= '0;
            best_sum_reg  <= DIST_MAX;
            best_idx_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            dist_reg      <= dist_next;
            cnt_reg       <= cnt_next;
            best_sum_reg  <= best_sum_next;
            best_idx_reg  <= best_idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_ready && pixel.valid)
        begin
            op_reg        <= pixel.opcode;
            red_reg       <= pixel.red;
            green_reg     <= pixel.green;
            blue_reg      <= pixel.blue;
            last_reg      <= pixel.last_pixel;
            last_cand_reg <= pixel.last_candidate;
        end
        if (state_reg == ST_FETCH)
        begin
            sum_r_reg <= sum_r;
            sum_g_reg <= sum_g;
            sum_b_reg <= sum_b;
        end
        if (state_reg == ST_SCALE)
        begin
            avg_r_reg <= prod_r[RECIP_SHIFT +: COLOR_W];
            avg_g_reg <= prod_g[RECIP_SHIFT +: COLOR_W];
            avg_b_reg <= prod_b[RECIP_SHIFT +: COLOR_W];
        end
        if (state_reg == ST_SQUARE)
        begin
            sq_r_reg <= SQ_W'(diff_r) * SQ_W'(diff_r);
            sq_g_reg <= SQ_W'(diff_g) * SQ_W'(diff_g);
            sq_b_reg <= SQ_W'(diff_b) * SQ_W'(diff_b);
        end
        if (res_load)
        begin
            res_cand_reg      <= NUM_W'(cnt_reg);
            res_dist_reg      <= dist_sat;
            res_best_num_reg  <= NUM_W'(new_best_idx);
            res_best_dist_reg <= new_best_sum;
            res_done_reg      <= last_cand_reg;
        end
    end

    assign result.valid            = res_valid_reg;
    assign result.candidate_number = res_cand_reg;
    assign result.distance         = res_dist_reg;
    assign result.best_number      = res_best_num_reg;
    assign result.best_distance    = res_best_dist_reg;
    assign result.search_done      = res_done_reg;

endmodule

/* rtl/rasbm_checker.sv */
// ----------------------------------------------------------------------------
// rasbm_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rasbm_checker
    import rasbm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_ready,
    input logic [NUM_W-1:0]  candidate_number,
    input logic [DIST_W-1:0] distance,
    input logic [NUM_W-1:0]  best_number,
    input logic [DIST_W-1:0] best_distance,
    input logic              search_done
);

    `RASBM_ASSERT_NEXT(a_valid_hold, clk, rst_n, result_valid && !result_ready, result_valid)
    `RASBM_ASSERT_NEXT(a_word_hold, clk, rst_n, result_valid && !result_ready, $stable(distance) && $stable(best_distance) && $stable(candidate_number) && $stable(best_number) && $stable(search_done))
    `RASBM_ASSERT_NOW(a_best_bound, clk, rst_n, result_valid, best_distance <= distance && best_number <= candidate_number)
    `RASBM_ASSERT_NOW(a_first_is_best, clk, rst_n, result_valid && candidate_number == '0, best_number == '0 && best_distance == distance)

endmodule

bind recent_average_ssd_best_match rasbm_checker u_rasbm_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .candidate_number (result.candidate_number),
    .distance         (result.distance),
    .best_number      (result.best_number),
    .best_distance    (result.best_distance),
    .search_done      (result.search_done)
);
